### rtl/core/iirl_pkg.sv
package iirl_pkg;

  // field widths of the command and result items
  localparam int unsigned CmdW   = 2;
  localparam int unsigned IndexW = 5;
  localparam int unsigned WordW  = 32;
  localparam int unsigned StatW  = 2;
  localparam int unsigned CountW = 5;

  // default number of list entries
  localparam int unsigned DefaultDepth = 16;

  // command codes
  typedef enum logic [CmdW-1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_READ   = 2'd2,
    CMD_WRITE  = 2'd3
  } cmd_e;

  // status codes
  localparam logic [StatW-1:0] ST_DONE      = 2'd0;
  localparam logic [StatW-1:0] ST_BAD_INDEX = 2'd1;
  localparam logic [StatW-1:0] ST_FULL      = 2'd2;

  // operation applied to the entry row
  typedef enum logic [1:0] {
    SOP_NONE   = 2'd0,
    SOP_INSERT = 2'd1,
    SOP_REMOVE = 2'd2,
    SOP_WRITE  = 2'd3
  } store_op_e;

  typedef struct packed {
    store_op_e          op;
    logic [IndexW-1:0]  index;
  } store_ctl_t;

  typedef struct packed {
    cmd_e                     cmd;
    logic [IndexW-1:0]        index;
    logic signed [WordW-1:0]  value;
  } req_t;

  typedef struct packed {
    logic [StatW-1:0]         status;
    logic signed [WordW-1:0]  read_value;
    logic [CountW-1:0]        count;
    logic signed [WordW-1:0]  total;
  } rsp_t;

endpackage

### rtl/core/iirl_store.sv
module iirl_store #(
  parameter int unsigned DEPTH = iirl_pkg::DefaultDepth
) (
  input  logic                                  clk_i,
  input  iirl_pkg::store_ctl_t                  ctl_i,
  input  logic [$clog2(DEPTH+1)-1:0]            count_i,
  input  logic signed [iirl_pkg::WordW-1:0]     value_i,
  output logic signed [iirl_pkg::WordW-1:0]     rd_word_o
);
  import iirl_pkg::*;

  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned CmpW = (CntW > IndexW) ? CntW : IndexW;

  logic signed [WordW-1:0] entries_q [DEPTH];
  logic signed [WordW-1:0] entries_d [DEPTH];
  logic signed [WordW-1:0] prev_w    [DEPTH];
  logic signed [WordW-1:0] succ_w    [DEPTH];
  logic [CmpW-1:0]         idx_x;
  logic [CmpW-1:0]         cnt_x;

  assign idx_x = CmpW'(ctl_i.index);
  assign cnt_x = CmpW'(count_i);

  // word at the addressed position
  always_comb begin
    rd_word_o = '0;
    for (int unsigned i = 0; i < DEPTH; i++) begin
      if (idx_x == CmpW'(i)) begin
        rd_word_o = entries_q[i];
      end
    end
  end

  // each cell takes its neighbor, the new word, zero, or holds
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    localparam logic [CmpW-1:0] Pos     = CmpW'(g);
    localparam logic [CmpW-1:0] PosNext = CmpW'(g + 1);

    if (g == 0) begin : g_first
      assign prev_w[g] = '0;
    end else begin : g_inner
      assign prev_w[g] = entries_q[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign succ_w[g] = '0;
    end else begin : g_body
      assign succ_w[g] = entries_q[g+1];
    end

    always_comb begin
      entries_d[g] = entries_q[g];
      unique case (ctl_i.op)
        SOP_INSERT: begin
          if (Pos == idx_x) begin
            entries_d[g] = value_i;
          end else if (Pos > idx_x && Pos <= cnt_x) begin
            entries_d[g] = prev_w[g];
          end
        end
        SOP_REMOVE: begin
          if (PosNext == cnt_x) begin
            entries_d[g] = '0;
          end else if (Pos >= idx_x && PosNext < cnt_x) begin
            entries_d[g] = succ_w[g];
          end
        end
        SOP_WRITE: begin
          if (Pos == idx_x) begin
            entries_d[g] = value_i;
          end
        end
        default: begin
          entries_d[g] = entries_q[g];
        end
      endcase
    end
  end

  // entry row
  always_ff @(posedge clk_i) begin
    entries_q <= entries_d;
  end

endmodule

### rtl/core/indexed_insert_remove_list.sv
// channel   | ports                       | direction | payload
// ----------+-----------------------------+-----------+------------------------------
// command   | start, busy, req_i          | in        | cmd, index, value
// result    | rsp_valid_o, rsp_o          | out       | status, read_value, count, total
//
// one item is accepted per cycle; busy stays low, so start may be held high
// the result strobe comes two cycles after acceptance: input register, then the
// single-pass update of the entry row, count and sum into the result register
// rst_ni clears the count, the sum and the pipeline valids; entries need no reset
// the receiver cannot stall: each result is on rsp_o for exactly one cycle
module indexed_insert_remove_list #(
  parameter int unsigned DEPTH = iirl_pkg::DefaultDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  iirl_pkg::req_t req_i,
  output logic           rsp_valid_o,
  output iirl_pkg::rsp_t rsp_o
);
  import iirl_pkg::*;

  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned CmpW = (CntW > IndexW) ? CntW : IndexW;

  req_t                    req_q;
  logic                    req_valid_q;
  logic [CntW-1:0]         cnt_q, cnt_d;
  logic signed [WordW-1:0] sum_q, sum_d;
  rsp_t                    rsp_q;
  logic                    rsp_valid_q;

  store_ctl_t              store_ctl;
  logic signed [WordW-1:0] rd_word;
  logic signed [WordW-1:0] delta;
  logic signed [WordW-1:0] rd_d;
  logic [StatW-1:0]        status_d;
  logic [CmpW-1:0]         idx_x;
  logic [CmpW-1:0]         cnt_x;

  assign busy = 1'b0;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else begin
      req_valid_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      req_q <= req_i;
    end
  end

  // index checks and command decode
  assign idx_x = CmpW'(req_q.index);
  assign cnt_x = CmpW'(cnt_q);

  always_comb begin
    status_d        = ST_DONE;
    store_ctl.op    = SOP_NONE;
    store_ctl.index = req_q.index;
    cnt_d           = cnt_q;
    delta           = '0;
    rd_d            = '0;
    if (req_valid_q) begin
      unique case (req_q.cmd)
        CMD_INSERT: begin
          if (idx_x > cnt_x) begin
            status_d = ST_BAD_INDEX;
          end else if (cnt_q == CntW'(DEPTH)) begin
            status_d = ST_FULL;
          end else begin
            store_ctl.op = SOP_INSERT;
            cnt_d        = cnt_q + 1'b1;
            delta        = req_q.value;
          end
        end
        CMD_REMOVE: begin
          if (idx_x >= cnt_x) begin
            status_d = ST_BAD_INDEX;
          end else begin
            store_ctl.op = SOP_REMOVE;
            cnt_d        = cnt_q - 1'b1;
            delta        = -rd_word;
          end
        end
        CMD_READ: begin
          if (idx_x >= cnt_x) begin
            status_d = ST_BAD_INDEX;
          end else begin
            rd_d = rd_word;
          end
        end
        CMD_WRITE: begin
          if (idx_x >= cnt_x) begin
            status_d = ST_BAD_INDEX;
          end else begin
            store_ctl.op = SOP_WRITE;
            delta        = req_q.value - rd_word;
          end
        end
        default: begin
          status_d = ST_DONE;
        end
      endcase
    end
  end

  // running wrapping sum
  assign sum_d = sum_q + delta;

  // entry row with its shift logic
  iirl_store #(
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i     (clk_i),
    .ctl_i     (store_ctl),
    .count_i   (cnt_q),
    .value_i   (req_q.value),
    .rd_word_o (rd_word)
  );

  // count and sum state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      sum_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      sum_q <= sum_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else begin
      rsp_valid_q <= req_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_valid_q) begin
      rsp_q.status     <= status_d;
      rsp_q.read_value <= rd_d;
      rsp_q.count      <= CountW'(cnt_d);
      rsp_q.total      <= sum_d;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  // count never passes the capacity
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(DEPTH))
    else $error("list count above capacity");

  // a full rejection only happens at capacity
  a_full_at_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_q && status_d == ST_FULL) |-> cnt_q == CntW'(DEPTH))
    else $error("full status below capacity");

  // a completed remove shrinks the list by one
  a_remove_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_q && req_q.cmd == CMD_REMOVE && status_d == ST_DONE)
      |=> cnt_q == CntW'($past(cnt_q) - 1'b1))
    else $error("remove did not shrink the list");

  // reads and writes leave the count alone
  a_rw_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_q && (req_q.cmd == CMD_READ || req_q.cmd == CMD_WRITE))
      |=> $stable(cnt_q))
    else $error("read or write changed the count");

endmodule

### bench/indexed_insert_remove_list_checker.sv
`timescale 1ns / 100ps

module indexed_insert_remove_list_checker #(
  parameter int unsigned DEPTH = iirl_pkg::DefaultDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic           busy_i,
  input  iirl_pkg::req_t req_i,
  input  logic           rsp_valid_i,
  input  iirl_pkg::rsp_t rsp_i,
  output int unsigned    fail_count_o,
  output int unsigned    pending_o
);

  import iirl_pkg::*;

  localparam int unsigned OWED_DEPTH = 64;

  // shadow copy of the list, its length and its running sum
  logic signed [WordW-1:0] list_words [DEPTH];
  int unsigned             list_len;
  logic signed [WordW-1:0] list_sum;

  // results still owed by the block, a ring kept oldest first
  rsp_t        owed_results [OWED_DEPTH];
  int unsigned owed_head;
  int unsigned owed_tail;
  int unsigned owed_used;
  int unsigned mismatch_cnt;
  int unsigned result_no;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    mismatch_cnt = 0;
    result_no    = 0;
  end

  // apply one command to the shadow list and build the result it gives
  function automatic rsp_t apply_command(input req_t c);
    rsp_t        r;
    int unsigned pos;
    int          i;
    r   = '0;
    pos = c.index;
    r.status = ST_DONE;
    case (c.cmd)
      CMD_INSERT: begin
        if (pos > list_len) begin
          r.status = ST_BAD_INDEX;
        end else if (list_len >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          for (i = int'(list_len); i > int'(pos); i--) begin
            list_words[i] = list_words[i-1];
          end
          list_words[pos] = c.value;
          list_len++;
          list_sum += c.value;
        end
      end
      CMD_REMOVE: begin
        if (pos >= list_len) begin
          r.status = ST_BAD_INDEX;
        end else begin
          list_sum -= list_words[pos];
          for (i = int'(pos); i + 1 < int'(list_len); i++) begin
            list_words[i] = list_words[i+1];
          end
          list_len--;
          list_words[list_len] = '0;
        end
      end
      CMD_READ: begin
        if (pos >= list_len) begin
          r.status = ST_BAD_INDEX;
        end else begin
          r.read_value = list_words[pos];
        end
      end
      default: begin
        if (pos >= list_len) begin
          r.status = ST_BAD_INDEX;
        end else begin
          list_sum += c.value - list_words[pos];
          list_words[pos] = c.value;
        end
      end
    endcase
    r.count = list_len[CountW-1:0];
    r.total = list_sum;
    return r;
  endfunction

  // count a mismatch, report only the first few
  task automatic flag_mismatch(input string what, input longint want_v, input longint got_v);
    if (mismatch_cnt < 10) begin
      $display("%0t: result %0d %s mismatch, expected %0d, got %0d",
               $time, result_no, what, want_v, got_v);
    end
    mismatch_cnt++;
  endtask

  // record accepted items and compare each result with the oldest one owed
  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    int   k;
    if (!rst_ni) begin
      owed_head = 0;
      owed_tail = 0;
      owed_used = 0;
      for (k = 0; k < int'(DEPTH); k++) begin
        list_words[k] = '0;
      end
      list_len = 0;
      list_sum = '0;
    end else begin
      if (start_i && !busy_i) begin
        owed_results[owed_tail] = apply_command(req_i);
        owed_tail = (owed_tail + 1) % OWED_DEPTH;
        owed_used++;
      end
      if (rsp_valid_i) begin
        if (owed_used == 0) begin
          if (mismatch_cnt < 10) begin
            $display("%0t: result %0d arrived with nothing owed", $time, result_no);
          end
          mismatch_cnt++;
        end else begin
          want      = owed_results[owed_head];
          owed_head = (owed_head + 1) % OWED_DEPTH;
          owed_used--;
          if (rsp_i.status !== want.status) begin
            flag_mismatch("status", want.status, rsp_i.status);
          end
          if (rsp_i.read_value !== want.read_value) begin
            flag_mismatch("read_value", want.read_value, rsp_i.read_value);
          end
          if (rsp_i.count !== want.count) begin
            flag_mismatch("count", want.count, rsp_i.count);
          end
          if (rsp_i.total !== want.total) begin
            flag_mismatch("total", want.total, rsp_i.total);
          end
        end
        result_no++;
      end
    end
    pending_o    = owed_used;
    fail_count_o = mismatch_cnt;
  end

endmodule

### bench/indexed_insert_remove_list_test.sv
`timescale 1ns / 100ps

module indexed_insert_remove_list_test;

  import iirl_pkg::*;

  localparam int unsigned DEPTH       = DefaultDepth;
  localparam int unsigned RANDOM_CMDS = 600;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_WAIT  = 8;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        start;
  logic        busy;
  req_t        req_i;
  logic        rsp_valid_o;
  rsp_t        rsp_o;
  int unsigned fail_count;
  int unsigned pending;

  // length of the list as the stimulus sees it, used to aim indexes
  int unsigned list_len;
  int unsigned cycle_cnt;

  always #5 clk_i = ~clk_i;

  indexed_insert_remove_list #(
    .DEPTH(DEPTH)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .rsp_valid_o(rsp_valid_o),
    .rsp_o      (rsp_o)
  );

  indexed_insert_remove_list_checker #(
    .DEPTH(DEPTH)
  ) list_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .busy_i      (busy),
    .req_i       (req_i),
    .rsp_valid_i (rsp_valid_o),
    .rsp_i       (rsp_o),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // offer one item and hold it until the block takes it
  task automatic send_cmd(input cmd_e c, input int unsigned pos, input logic [WordW-1:0] v);
    logic taken;
    start       <= 1'b1;
    req_i.cmd   <= c;
    req_i.index <= pos[IndexW-1:0];
    req_i.value <= v;
    do begin
      @(negedge clk_i);
      taken = !busy;
      @(posedge clk_i);
    end while (!taken);
    // follow the list length for index aiming
    if (c == CMD_INSERT && pos <= list_len && list_len < DEPTH) begin
      list_len++;
    end else if (c == CMD_REMOVE && pos < list_len) begin
      list_len--;
    end
  endtask

  // drop start for a number of cycles
  task automatic hold_off(input int unsigned n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // wait until every owed result has come back
  task automatic wait_drained();
    start <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
  endtask

  function automatic logic [WordW-1:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return 32'hffff_ffff;
      3:       return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  // cycle limit in case the block hangs
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("indexed_insert_remove_list_test: done, errors");
    $finish;
  end

  // stimulus and verdict
  initial begin
    int unsigned n;
    int unsigned roll;
    int unsigned pos;
    int unsigned grow_pct;
    int unsigned shrink_pct;
    bit          gappy;
    cmd_e        c;

    rst_ni   <= 1'b0;
    start    <= 1'b0;
    req_i    <= '0;
    list_len = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty list: every access is out of range
    send_cmd(CMD_READ, 0, 32'h1234_5678);
    send_cmd(CMD_REMOVE, 0, 32'h0);
    send_cmd(CMD_WRITE, 0, 32'h5555_aaaa);
    send_cmd(CMD_INSERT, 1, 32'h1);
    send_cmd(CMD_INSERT, 31, 32'h2);
    // front and back inserts with extreme words, sum wraps
    send_cmd(CMD_INSERT, 0, 32'h7fff_ffff);
    send_cmd(CMD_INSERT, 1, 32'h8000_0000);
    send_cmd(CMD_INSERT, 0, 32'hffff_ffff);
    send_cmd(CMD_READ, 1, 32'h0);
    send_cmd(CMD_WRITE, 2, 32'h7fff_ffff);
    send_cmd(CMD_REMOVE, 1, 32'h0);
    send_cmd(CMD_READ, 2, 32'h0);
    // fill the store, then hit the full case and the bad index that beats it
    while (list_len < DEPTH) begin
      send_cmd(CMD_INSERT, $urandom_range(0, list_len), pick_word());
    end
    send_cmd(CMD_INSERT, DEPTH, 32'h3);
    send_cmd(CMD_INSERT, DEPTH + 1, 32'h4);
    send_cmd(CMD_READ, DEPTH - 1, 32'h0);
    send_cmd(CMD_REMOVE, DEPTH - 1, 32'h0);
    send_cmd(CMD_REMOVE, 0, 32'h0);
    send_cmd(CMD_WRITE, 0, 32'h8000_0000);
    wait_drained();

    // random commands in phases that grow, shrink or churn the list
    grow_pct   = 40;
    shrink_pct = 20;
    gappy      = 1'b0;
    for (n = 0; n < RANDOM_CMDS; n++) begin
      if (n % 50 == 0) begin
        case ($urandom_range(0, 2))
          0:       begin grow_pct = 60; shrink_pct = 15; end
          1:       begin grow_pct = 15; shrink_pct = 60; end
          default: begin grow_pct = 35; shrink_pct = 30; end
        endcase
      end
      if (n % 20 == 0) begin
        gappy = $urandom_range(0, 2) != 0;
      end
      if (n == RANDOM_CMDS / 2) begin
        wait_drained();
      end

      roll = $urandom_range(0, 99);
      if (roll < grow_pct) begin
        c = CMD_INSERT;
      end else if (roll < grow_pct + shrink_pct) begin
        c = CMD_REMOVE;
      end else if (roll % 2 == 0) begin
        c = CMD_READ;
      end else begin
        c = CMD_WRITE;
      end

      // mostly valid positions, some out of range, a few anywhere in the field
      roll = $urandom_range(0, 99);
      if (roll < 85) begin
        if (c == CMD_INSERT) begin
          pos = $urandom_range(0, list_len);
        end else begin
          pos = (list_len == 0) ? 0 : $urandom_range(0, list_len - 1);
        end
      end else if (roll < 95) begin
        pos = $urandom_range(0, DEPTH);
      end else begin
        pos = $urandom_range(0, (1 << IndexW) - 1);
      end

      send_cmd(c, pos, pick_word());

      if (gappy) begin
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
          hold_off(0);
        end else if (roll < 90) begin
          hold_off($urandom_range(1, 3));
        end else begin
          hold_off($urandom_range(8, 30));
        end
      end
    end

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("indexed_insert_remove_list_test: done, clean");
    end else begin
      $display("indexed_insert_remove_list_test: done, errors");
    end
    $finish;
  end

endmodule
